### sv/natural_cubic_spline_coefficients_unit_assert.svh
// Assertion macros for the spline coefficient unit.
`ifndef NATURAL_CUBIC_SPLINE_COEFFICIENTS_UNIT_ASSERT_SVH
`define NATURAL_CUBIC_SPLINE_COEFFICIENTS_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while rst is high.
`define NCS_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ncs: property violated");

// Next-cycle implication, disabled while rst is high.
`define NCS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ncs: property violated");

`endif

### sv/ncs_pkg.sv
package ncs_pkg;

   localparam int POINT_CNT_W = 7;
   localparam int GAMMA_W     = 17;
   localparam int DEN_W       = 19;
   localparam int DIV_STEPS   = 17;

   localparam logic [GAMMA_W-1:0] GAMMA_HALF = 17'd32768;
   localparam logic [DEN_W-1:0]   GAMMA_FOUR = 19'd262144;
   localparam logic [DEN_W-1:0]   GAMMA_TWO  = 19'd131072;

   typedef struct packed {
      logic signed [15:0] x_coord;
      logic signed [15:0] y_coord;
      logic               last_point;
   } req_type;

   typedef struct packed {
      logic [5:0]         segment_index;
      logic signed [31:0] ax;
      logic signed [31:0] bx;
      logic signed [31:0] cx;
      logic signed [31:0] dx_coef;
      logic signed [31:0] ay;
      logic signed [31:0] by_coef;
      logic signed [31:0] cy;
      logic signed [31:0] dy_coef;
      logic               last_segment;
   } rsp_type;

   // One classified point on its way to the solver
   typedef struct packed {
      logic signed [15:0]     x_coord;
      logic signed [15:0]     y_coord;
      logic                   keep;
      logic                   last_point;
      logic [POINT_CNT_W-1:0] count;
   } entry_type;

endpackage

### sv/natural_cubic_spline_coefficients_unit.sv
// Channel | Direction | Handshake          | Payload
// req_    | in        | req_valid/req_stall | x_coord, y_coord, last_point
// rsp_    | out       | rsp_valid/rsp_stall | segment_index, x/y a..d, last_segment
//
// Points enter a two-entry queue at one per cycle unless it is full; the solver stores
// one per cycle while idle. A closing point of N points runs a forward sweep (17-step
// gamma divider per point after the first), a backward sweep, then N-1 segments out.
// Reset is synchronous; the stores are not cleared, only control state.
// rsp_stall holds the output register; the solver waits, and req_stall rises only
// when the queue is full.
module natural_cubic_spline_coefficients_unit #(
   parameter int MAX_POINTS    = 64,
   parameter int FRACTION_BITS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ncs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ncs_pkg::rsp_type rsp_data
);
   import ncs_pkg::*;

   logic      q_full, q_push, q_valid, q_pop;
   entry_type q_in, q_out;

   ncs_front #(
      .MAX_POINTS (MAX_POINTS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (q_in)
   );

   ncs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_out)
   );

   ncs_back #(
      .MAX_POINTS    (MAX_POINTS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_entry   (q_out),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### sv/ncs_front.sv
module ncs_front #(
   parameter int MAX_POINTS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  ncs_pkg::req_type   req_data,
   input  logic               q_full,
   output logic               q_push,
   output ncs_pkg::entry_type q_entry
);
   import ncs_pkg::*;

   logic [POINT_CNT_W-1:0] count_ff, count_in;
   logic                   keep;
   logic [POINT_CNT_W-1:0] count_next;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   // Classify: keep the point while the run has room
   assign keep       = count_ff < POINT_CNT_W'(MAX_POINTS);
   assign count_next = keep ? count_ff + POINT_CNT_W'(1) : count_ff;

   assign q_entry.x_coord    = req_data.x_coord;
   assign q_entry.y_coord    = req_data.y_coord;
   assign q_entry.keep       = keep;
   assign q_entry.last_point = req_data.last_point;
   assign q_entry.count      = count_next;

   // Advance the run count, drop it on the closing point
   always_comb begin
      count_in = count_ff;
      if (q_push) begin
         count_in = req_data.last_point ? '0 : count_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

### sv/ncs_queue.sv
module ncs_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ncs_pkg::entry_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               valid,
   output ncs_pkg::entry_type pop_data
);
   import ncs_pkg::*;

   entry_type  slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   assign full     = fill_ff == 2'd2;
   assign valid    = fill_ff != 2'd0;
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Hold the payload slots
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### sv/ncs_gamma_div.sv
// Restoring divider: quot = round(2^32 / den), one quotient bit a cycle.
module ncs_gamma_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [ncs_pkg::DEN_W-1:0]    den,
   output logic                         done,
   output logic [ncs_pkg::GAMMA_W-1:0]  quot
);
   import ncs_pkg::*;

   logic [DEN_W-1:0]   den_ff, den_in;
   logic [DEN_W-1:0]   rem_ff, rem_in;
   logic [16:0]        num_ff, num_in;
   logic [GAMMA_W-1:0] quot_ff, quot_in;
   logic [4:0]         step_ff, step_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [DEN_W:0]     trial;

   assign done  = done_ff;
   assign quot  = quot_ff;
   assign trial = {rem_ff, num_ff[16]};

   always_comb begin
      den_in  = den_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      quot_in = quot_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // Numerator is 2^32 + den/2; its top bits already sit below den
         den_in  = den;
         rem_in  = DEN_W'(16'h8000) + DEN_W'(den[DEN_W-1]);
         num_in  = den[17:1];
         quot_in = '0;
         step_in = 5'(DIV_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in  = DEN_W'(trial - {1'b0, den_ff});
            quot_in = {quot_ff[GAMMA_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[DEN_W-1:0];
            quot_in = {quot_ff[GAMMA_W-2:0], 1'b0};
         end
         num_in  = {num_ff[15:0], 1'b0};
         step_in = step_ff - 5'd1;
         if (step_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      quot_ff <= quot_in;
      step_ff <= step_in;
   end

endmodule

### sv/ncs_back.sv
module ncs_back #(
   parameter int MAX_POINTS    = 64,
   parameter int FRACTION_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   output logic               q_pop,
   input  ncs_pkg::entry_type q_entry,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output ncs_pkg::rsp_type   rsp_data
);
   import ncs_pkg::*;

   localparam int IW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
   localparam int VW = ((FRACTION_BITS + 19 > 32) ? FRACTION_BITS + 19 : 32) + 1;
   localparam int HW = VW - 18;

   typedef enum logic [3:0] {
      ST_IDLE, ST_FWD_GAM, ST_FWD_DIV, ST_FWD_RD, ST_FWD_ML, ST_FWD_MH, ST_FWD_FIN,
      ST_BWD_RD, ST_BWD_ML, ST_BWD_FIN, ST_EM_RD, ST_EM_OUT
   } state_type;

   typedef struct packed {
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic signed [31:0] c;
      logic signed [31:0] d;
   } coef_type;

   function automatic logic signed [63:0] rnd16(input logic signed [63:0] v);
      rnd16 = (v + (v[63] ? 64'sd32767 : 64'sd32768)) >>> 16;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         sat32 = 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         sat32 = 32'sh80000000;
      end else begin
         sat32 = v[31:0];
      end
   endfunction

   function automatic coef_type seg_coef(input logic signed [15:0] p0s,
                                         input logic signed [15:0] p1s,
                                         input logic signed [31:0] t0s,
                                         input logic signed [31:0] t1s);
      logic signed [63:0] p0, p1, t0, t1, dp;
      coef_type           r;
      p0  = 64'(p0s);
      p1  = 64'(p1s);
      t0  = 64'(t0s);
      t1  = 64'(t1s);
      dp  = p1 - p0;
      r.a = sat32(p0 <<< FRACTION_BITS);
      r.b = t0s;
      r.c = sat32(((dp + (dp <<< 1)) <<< FRACTION_BITS) - (t0 <<< 1) - t1);
      r.d = sat32((((p0 - p1) <<< 1) <<< FRACTION_BITS) + t0 + t1);
      seg_coef = r;
   endfunction

   // Sequencer and registered output
   state_type              state_ff, state_in;
   logic [POINT_CNT_W-1:0] n_ff, n_in;
   logic [IW-1:0]          i_ff, i_in;
   logic [GAMMA_W-1:0]     g_ff, g_in;
   logic signed [31:0]     acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;
   logic [17:0]            vlo_x_ff, vlo_x_in, vlo_y_ff, vlo_y_in;
   logic signed [HW-1:0]   vhi_x_ff, vhi_x_in, vhi_y_ff, vhi_y_in;
   logic [34:0]            plo_x_ff, plo_x_in, plo_y_ff, plo_y_in;
   logic signed [VW-1:0]   phi_x_ff, phi_x_in, phi_y_ff, phi_y_in;
   logic signed [49:0]     pb_x_ff, pb_x_in, pb_y_ff, pb_y_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   // Memories and their read registers
   logic signed [15:0]  px_mem [MAX_POINTS];
   logic signed [15:0]  py_mem [MAX_POINTS];
   logic signed [31:0]  dlx_mem [MAX_POINTS];
   logic signed [31:0]  dly_mem [MAX_POINTS];
   logic signed [31:0]  tnx_mem [MAX_POINTS];
   logic signed [31:0]  tny_mem [MAX_POINTS];
   logic [GAMMA_W-1:0]  gam_mem [MAX_POINTS];
   logic signed [15:0]  px_lo_rd, px_hi_rd, py_lo_rd, py_hi_rd;
   logic signed [31:0]  dlx_rd, dly_rd;
   logic signed [31:0]  tnx_lo_rd, tnx_hi_rd, tny_lo_rd, tny_hi_rd;
   logic [GAMMA_W-1:0]  gam_rd;

   logic                   div_start, div_done;
   logic [DEN_W-1:0]       div_den;
   logic [GAMMA_W-1:0]     div_quot;
   logic [POINT_CNT_W-1:0] i_ext, wr_cnt;
   logic                   is_first, is_last, emit_st, out_free;
   logic [IW-1:0]          addr_lo, addr_hi, i_inc, i_dec, pt_wa, tn_wa;
   logic                   pt_we, dl_we, gam_we, tn_we;
   logic signed [16:0]     diff_x, diff_y;
   logic signed [VW-1:0]   v_x, v_y;
   logic signed [63:0]     sum_x, sum_y;
   logic signed [31:0]     dnew_x, dnew_y, tnew_x, tnew_y, tn_wd_x, tn_wd_y;
   coef_type               cf_x, cf_y;

   ncs_gamma_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign i_ext    = POINT_CNT_W'(i_ff);
   assign is_first = i_ff == '0;
   assign is_last  = i_ext == n_ff - POINT_CNT_W'(1);
   assign emit_st  = (state_ff == ST_EM_RD) || (state_ff == ST_EM_OUT);
   assign i_inc    = i_ff + IW'(1);
   assign i_dec    = i_ff - IW'(1);

   // Neighbor addresses: forward sweep taps, backward row, emit pair
   always_comb begin
      if (emit_st) begin
         addr_lo = i_ff;
         addr_hi = i_inc;
      end else if (is_first) begin
         addr_lo = '0;
         addr_hi = IW'(1);
      end else begin
         addr_lo = i_dec;
         addr_hi = is_last ? i_ff : i_inc;
      end
   end

   assign wr_cnt   = q_entry.count - POINT_CNT_W'(1);
   assign pt_wa    = wr_cnt[IW-1:0];
   assign q_pop    = (state_ff == ST_IDLE) && q_valid;
   assign pt_we    = q_pop && q_entry.keep;
   assign gam_we   = state_ff == ST_FWD_RD;
   assign dl_we    = state_ff == ST_FWD_FIN;
   assign tn_we    = ((state_ff == ST_FWD_FIN) && is_last) || (state_ff == ST_BWD_FIN);
   assign tn_wa    = (state_ff == ST_BWD_FIN) ? addr_lo : i_ff;
   assign div_den  = (is_last ? GAMMA_TWO : GAMMA_FOUR) - DEN_W'(g_ff);
   assign div_start = (state_ff == ST_FWD_GAM) && !is_first;

   // Forward right-hand side: 3*(p_hi - p_lo)*2^F - previous delta
   assign diff_x = 17'(px_hi_rd) - 17'(px_lo_rd);
   assign diff_y = 17'(py_hi_rd) - 17'(py_lo_rd);
   assign v_x = ((VW'(diff_x) + (VW'(diff_x) <<< 1)) <<< FRACTION_BITS) - VW'(acc_x_ff);
   assign v_y = ((VW'(diff_y) + (VW'(diff_y) <<< 1)) <<< FRACTION_BITS) - VW'(acc_y_ff);

   // Recombine partial products, then round and clamp
   assign sum_x  = (64'(phi_x_ff) <<< 18) + $signed(64'(plo_x_ff));
   assign sum_y  = (64'(phi_y_ff) <<< 18) + $signed(64'(plo_y_ff));
   assign dnew_x = sat32(rnd16(sum_x));
   assign dnew_y = sat32(rnd16(sum_y));

   assign tnew_x = sat32(64'(dlx_rd) - rnd16(64'(pb_x_ff)));
   assign tnew_y = sat32(64'(dly_rd) - rnd16(64'(pb_y_ff)));
   assign tn_wd_x = (state_ff == ST_BWD_FIN) ? tnew_x : dnew_x;
   assign tn_wd_y = (state_ff == ST_BWD_FIN) ? tnew_y : dnew_y;

   assign cf_x = seg_coef(px_lo_rd, px_hi_rd, tnx_lo_rd, tnx_hi_rd);
   assign cf_y = seg_coef(py_lo_rd, py_hi_rd, tny_lo_rd, tny_hi_rd);

   always_comb begin
      state_in  = state_ff;
      n_in      = n_ff;
      i_in      = i_ff;
      g_in      = g_ff;
      acc_x_in  = acc_x_ff;
      acc_y_in  = acc_y_ff;
      vlo_x_in  = vlo_x_ff;
      vlo_y_in  = vlo_y_ff;
      vhi_x_in  = vhi_x_ff;
      vhi_y_in  = vhi_y_ff;
      plo_x_in  = plo_x_ff;
      plo_y_in  = plo_y_ff;
      phi_x_in  = phi_x_ff;
      phi_y_in  = phi_y_ff;
      pb_x_in   = pb_x_ff;
      pb_y_in   = pb_y_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            // Store the point; a closing point with two or more starts the solve
            if (q_valid && q_entry.last_point) begin
               n_in = q_entry.count;
               if (q_entry.count >= POINT_CNT_W'(2)) begin
                  i_in     = '0;
                  acc_x_in = '0;
                  acc_y_in = '0;
                  state_in = ST_FWD_GAM;
               end
            end
         end
         ST_FWD_GAM: begin
            if (is_first) begin
               g_in     = GAMMA_HALF;
               state_in = ST_FWD_RD;
            end else begin
               state_in = ST_FWD_DIV;
            end
         end
         ST_FWD_DIV: begin
            if (div_done) begin
               g_in     = div_quot;
               state_in = ST_FWD_RD;
            end
         end
         ST_FWD_RD: begin
            vlo_x_in = v_x[17:0];
            vlo_y_in = v_y[17:0];
            vhi_x_in = v_x[VW-1:18];
            vhi_y_in = v_y[VW-1:18];
            state_in = ST_FWD_ML;
         end
         ST_FWD_ML: begin
            plo_x_in = 35'(vlo_x_ff) * 35'(g_ff);
            plo_y_in = 35'(vlo_y_ff) * 35'(g_ff);
            state_in = ST_FWD_MH;
         end
         ST_FWD_MH: begin
            phi_x_in = VW'(vhi_x_ff) * VW'($signed({1'b0, g_ff}));
            phi_y_in = VW'(vhi_y_ff) * VW'($signed({1'b0, g_ff}));
            state_in = ST_FWD_FIN;
         end
         ST_FWD_FIN: begin
            acc_x_in = dnew_x;
            acc_y_in = dnew_y;
            if (is_last) begin
               state_in = ST_BWD_RD;
            end else begin
               i_in     = i_inc;
               state_in = ST_FWD_GAM;
            end
         end
         ST_BWD_RD: begin
            state_in = ST_BWD_ML;
         end
         ST_BWD_ML: begin
            pb_x_in  = $signed({1'b0, gam_rd}) * acc_x_ff;
            pb_y_in  = $signed({1'b0, gam_rd}) * acc_y_ff;
            state_in = ST_BWD_FIN;
         end
         ST_BWD_FIN: begin
            acc_x_in = tnew_x;
            acc_y_in = tnew_y;
            i_in     = i_dec;
            state_in = (i_ff == IW'(1)) ? ST_EM_RD : ST_BWD_RD;
         end
         ST_EM_RD: begin
            state_in = ST_EM_OUT;
         end
         ST_EM_OUT: begin
            // Wait for the output register, then load one segment
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.segment_index = 6'(i_ff);
               rsp_data_in.ax            = cf_x.a;
               rsp_data_in.bx            = cf_x.b;
               rsp_data_in.cx            = cf_x.c;
               rsp_data_in.dx_coef       = cf_x.d;
               rsp_data_in.ay            = cf_y.a;
               rsp_data_in.by_coef       = cf_y.b;
               rsp_data_in.cy            = cf_y.c;
               rsp_data_in.dy_coef       = cf_y.d;
               rsp_data_in.last_segment  = (i_ext + POINT_CNT_W'(2)) == n_ff;
               if ((i_ext + POINT_CNT_W'(2)) == n_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  i_in     = i_inc;
                  state_in = ST_EM_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff        <= n_in;
      i_ff        <= i_in;
      g_ff        <= g_in;
      acc_x_ff    <= acc_x_in;
      acc_y_ff    <= acc_y_in;
      vlo_x_ff    <= vlo_x_in;
      vlo_y_ff    <= vlo_y_in;
      vhi_x_ff    <= vhi_x_in;
      vhi_y_ff    <= vhi_y_in;
      plo_x_ff    <= plo_x_in;
      plo_y_ff    <= plo_y_in;
      phi_x_ff    <= phi_x_in;
      phi_y_ff    <= phi_y_in;
      pb_x_ff     <= pb_x_in;
      pb_y_ff     <= pb_y_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Point stores: one write port, two read ports
   always_ff @(posedge clock) begin
      if (pt_we) begin
         px_mem[pt_wa] <= q_entry.x_coord;
         py_mem[pt_wa] <= q_entry.y_coord;
      end
      px_lo_rd <= px_mem[addr_lo];
      px_hi_rd <= px_mem[addr_hi];
      py_lo_rd <= py_mem[addr_lo];
      py_hi_rd <= py_mem[addr_hi];
   end

   // Forward sweep stores
   always_ff @(posedge clock) begin
      if (dl_we) begin
         dlx_mem[i_ff] <= dnew_x;
         dly_mem[i_ff] <= dnew_y;
      end
      dlx_rd <= dlx_mem[addr_lo];
      dly_rd <= dly_mem[addr_lo];
   end

   always_ff @(posedge clock) begin
      if (gam_we) begin
         gam_mem[i_ff] <= g_ff;
      end
      gam_rd <= gam_mem[addr_lo];
   end

   // Tangent stores
   always_ff @(posedge clock) begin
      if (tn_we) begin
         tnx_mem[tn_wa] <= tn_wd_x;
         tny_mem[tn_wa] <= tn_wd_y;
      end
      tnx_lo_rd <= tnx_mem[addr_lo];
      tnx_hi_rd <= tnx_mem[addr_hi];
      tny_lo_rd <= tny_mem[addr_lo];
      tny_hi_rd <= tny_mem[addr_hi];
   end

endmodule

### sv/ncs_checker.sv
`include "natural_cubic_spline_coefficients_unit_assert.svh"

module ncs_port_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input ncs_pkg::rsp_type rsp_data
);

   logic       rsp_wait;
   logic       mid_xfer;
   logic [5:0] idx;

   assign rsp_wait = rsp_valid && rsp_stall;
   assign mid_xfer = rsp_valid && !rsp_stall && !rsp_data.last_segment;
   assign idx      = rsp_data.segment_index;

   // Reset leaves no result pending and an empty queue
   `NCS_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid && !req_stall)

   // A stalled result holds
   `NCS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_valid && $stable(rsp_data))

   // Back-to-back segments of a run count up
   `NCS_ASSERT_IMPL(a_seg_step, clock, reset, (mid_xfer ##1 rsp_valid), idx == $past(idx) + 6'd1)

   // A new run cannot start emitting right after the last segment
   `NCS_ASSERT_NEXT(a_run_gap, clock, reset, rsp_valid && !rsp_stall && rsp_data.last_segment, !rsp_valid)

endmodule

bind natural_cubic_spline_coefficients_unit ncs_port_checker u_ncs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
